>>> rtl/vrst_pkg.sv
`timescale 1ns / 1ps
// vrst_pkg: constants, types and helper functions for the vertex transform
// used by vertex_rotate_scale_translate; depends on nothing else
package vrst_pkg;

  localparam int FullTurn    = 23040;
  localparam int QuarterTurn = 5760;
  localparam int CordicSteps = 16;
  localparam int CordicX0    = 326016437;
  localparam int UnitQ14     = 16384;

  // configuration register indexes
  localparam logic [2:0] REG_ANGLE_A = 3'd0;
  localparam logic [2:0] REG_ANGLE_B = 3'd1;
  localparam logic [2:0] REG_ANGLE_C = 3'd2;
  localparam logic [2:0] REG_SCALE   = 3'd3;
  localparam logic [2:0] REG_OFFSET  = 3'd4;

  localparam logic [47:0] ScaleReset = 48'h0100_0100_0100;

  typedef enum logic [2:0] {
    MB_IDLE,
    MB_LOAD,
    MB_REDUCE,
    MB_CORDIC,
    MB_FINISH,
    MB_COEF
  } mb_state_t;

  // atan(2^-i) in degrees scaled by 2^20
  function automatic logic signed [29:0] atan_lut(input logic [3:0] i);
    logic signed [29:0] v;
    unique case (i)
      4'd0:  v = 30'sd47185920;
      4'd1:  v = 30'sd27855475;
      4'd2:  v = 30'sd14718068;
      4'd3:  v = 30'sd7471121;
      4'd4:  v = 30'sd3750058;
      4'd5:  v = 30'sd1876857;
      4'd6:  v = 30'sd938658;
      4'd7:  v = 30'sd469357;
      4'd8:  v = 30'sd234682;
      4'd9:  v = 30'sd117342;
      4'd10: v = 30'sd58671;
      4'd11: v = 30'sd29335;
      4'd12: v = 30'sd14668;
      4'd13: v = 30'sd7334;
      4'd14: v = 30'sd3667;
      default: v = 30'sd1833;
    endcase
    return v;
  endfunction

  // clamp to the signed 16-bit range
  function automatic logic signed [15:0] sat16(input logic signed [51:0] v);
    logic signed [15:0] o;
    if (v > 52'sd32767) begin
      o = 16'sd32767;
    end else if (v < -52'sd32768) begin
      o = -16'sd32768;
    end else begin
      o = v[15:0];
    end
    return o;
  endfunction

  // clamp a sine or cosine to +-1.0 in Q1.14
  function automatic logic signed [15:0] sat_unit(input logic signed [17:0] v);
    logic signed [15:0] o;
    if (v > 18'sd16384) begin
      o = 16'sd16384;
    end else if (v < -18'sd16384) begin
      o = -16'sd16384;
    end else begin
      o = v[15:0];
    end
    return o;
  endfunction

endpackage

>>> rtl/vertex_rotate_scale_translate.sv
`timescale 1ns / 1ps
// vertex_rotate_scale_translate: rotation matrix builder and 4-stage
// vertex pipeline (rotate, sum, scale, offset); depends on vrst_pkg
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+--------------------
//  input    | in_pos_*, in_nrm_*                      | start & !busy
//  result   | out_new_pos_*, out_new_nrm_*            | out_valid, 1 cycle
//  config   | cfg_index, cfg_data                     | cfg_valid & cfg_ready
//
// one vertex per cycle while not busy
// an angle write rebuilds the matrix: per angle a load, one to three reduce
// steps, 16 cordic steps and a finish, then per coefficient a*b and d*e, the
// triple product, then the sum; busy and !cfg_ready hold during the rebuild
// sync reset gives identity matrix, a scale of 1/256 and zero offset
// the pipeline never stalls, results leave on the out_valid strobe

module vertex_rotate_scale_translate (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic signed [15:0] in_pos_z,
  input  logic signed [15:0] in_nrm_x,
  input  logic signed [15:0] in_nrm_y,
  input  logic signed [15:0] in_nrm_z,
  output logic               out_valid,
  output logic signed [15:0] out_new_pos_x,
  output logic signed [15:0] out_new_pos_y,
  output logic signed [15:0] out_new_pos_z,
  output logic signed [15:0] out_new_nrm_x,
  output logic signed [15:0] out_new_nrm_y,
  output logic signed [15:0] out_new_nrm_z,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [47:0]        cfg_data
);

  // ---------------- configuration ----------------
  logic signed [15:0] angle_r [3];
  logic [47:0]        scale_r;
  logic [47:0]        offset_r;
  logic               cfg_we;
  logic               ang_we;

  vrst_pkg::mb_state_t state_r, state_nxt;

  assign busy      = (state_r != vrst_pkg::MB_IDLE);
  assign cfg_ready = !busy;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign ang_we    = cfg_we && ((cfg_index == vrst_pkg::REG_ANGLE_A) ||
                                (cfg_index == vrst_pkg::REG_ANGLE_B) ||
                                (cfg_index == vrst_pkg::REG_ANGLE_C));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_r[0] <= '0;
      angle_r[1] <= '0;
      angle_r[2] <= '0;
      scale_r    <= vrst_pkg::ScaleReset;
      offset_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vrst_pkg::REG_ANGLE_A: angle_r[0] <= cfg_data[15:0];
        vrst_pkg::REG_ANGLE_B: angle_r[1] <= cfg_data[15:0];
        vrst_pkg::REG_ANGLE_C: angle_r[2] <= cfg_data[15:0];
        vrst_pkg::REG_SCALE:   scale_r    <= cfg_data;
        vrst_pkg::REG_OFFSET:  offset_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- matrix builder ----------------
  logic [1:0]         ang_idx_r;
  logic signed [16:0] r_r;
  logic signed [31:0] x_r, y_r;
  logic signed [29:0] z_r;
  logic [3:0]         iter_r;
  logic [1:0]         q_r;
  logic               zero_r;
  logic signed [15:0] sn_r [3];
  logic signed [15:0] cs_r [3];
  logic [3:0]         cidx_r;
  logic [1:0]         ph_r;
  logic signed [31:0] m1_r, m2_r;
  logic signed [47:0] t_r;
  logic signed [45:0] d_r;
  logic signed [15:0] coef_r [9];

  logic               in_range;
  logic [1:0]         q_w;
  logic signed [16:0] rem_w;
  logic signed [31:0] xs_w, ys_w;
  logic signed [15:0] s_w, c_w, sn_w, cs_w;
  logic signed [32:0] xr_w, yr_w;
  logic signed [17:0] xq_w, yq_w;

  assign in_range = (r_r >= 17'sd0) && (r_r < 17'(vrst_pkg::FullTurn));

  always_comb begin
    if (r_r >= 17'(3 * vrst_pkg::QuarterTurn)) begin
      q_w   = 2'd3;
      rem_w = r_r - 17'(3 * vrst_pkg::QuarterTurn);
    end else if (r_r >= 17'(2 * vrst_pkg::QuarterTurn)) begin
      q_w   = 2'd2;
      rem_w = r_r - 17'(2 * vrst_pkg::QuarterTurn);
    end else if (r_r >= 17'(vrst_pkg::QuarterTurn)) begin
      q_w   = 2'd1;
      rem_w = r_r - 17'(vrst_pkg::QuarterTurn);
    end else begin
      q_w   = 2'd0;
      rem_w = r_r;
    end
  end

  assign xs_w = x_r >>> iter_r;
  assign ys_w = y_r >>> iter_r;
  assign xr_w = 33'(x_r) + 33'sd16384;
  assign yr_w = 33'(y_r) + 33'sd16384;
  assign xq_w = xr_w[32:15];
  assign yq_w = yr_w[32:15];

  always_comb begin
    if (zero_r) begin
      s_w = 16'sd0;
      c_w = 16'(vrst_pkg::UnitQ14);
    end else begin
      s_w = vrst_pkg::sat_unit(yq_w);
      c_w = vrst_pkg::sat_unit(xq_w);
    end
    unique case (q_r)
      2'd0: begin sn_w = s_w;  cs_w = c_w;  end
      2'd1: begin sn_w = c_w;  cs_w = -s_w; end
      2'd2: begin sn_w = -s_w; cs_w = -c_w; end
      default: begin sn_w = -c_w; cs_w = s_w; end
    endcase
  end

  // coefficient = ((+-) a*b*c + dsg * d*e*2^14) / 2^28, rounded and saturated
  logic signed [15:0] op_a, op_b, op_c, op_d, op_e;
  logic               neg_t;
  logic signed [1:0]  dsg;
  localparam logic signed [15:0] K = 16'(vrst_pkg::UnitQ14);

  always_comb begin
    op_a = K; op_b = K; op_c = K; op_d = '0; op_e = '0;
    neg_t = 1'b0; dsg = 2'sd0;
    unique case (cidx_r)
      4'd0: begin op_a = cs_r[0]; op_b = cs_r[1]; end
      4'd1: begin
        op_a = cs_r[0]; op_b = sn_r[1]; op_c = sn_r[2];
        op_d = sn_r[0]; op_e = cs_r[2]; dsg = -2'sd1;
      end
      4'd2: begin
        op_a = cs_r[0]; op_b = sn_r[1]; op_c = cs_r[2];
        op_d = sn_r[0]; op_e = sn_r[2]; dsg = 2'sd1;
      end
      4'd3: begin op_a = sn_r[0]; op_b = cs_r[1]; end
      4'd4: begin
        op_a = sn_r[0]; op_b = sn_r[1]; op_c = sn_r[2];
        op_d = cs_r[0]; op_e = cs_r[2]; dsg = 2'sd1;
      end
      4'd5: begin
        op_a = sn_r[0]; op_b = sn_r[1]; op_c = cs_r[2];
        op_d = cs_r[0]; op_e = sn_r[2]; dsg = -2'sd1;
      end
      4'd6: begin op_a = sn_r[1]; neg_t = 1'b1; end
      4'd7: begin op_a = cs_r[1]; op_b = sn_r[2]; end
      4'd8: begin op_a = cs_r[1]; op_b = cs_r[2]; end
      default: ;
    endcase
  end

  logic signed [51:0] csum_w;
  logic signed [51:0] cshift_w;
  always_comb begin
    csum_w = neg_t ? -52'(t_r) : 52'(t_r);
    if (dsg > 2'sd0) begin
      csum_w = csum_w + 52'(d_r);
    end else if (dsg < 2'sd0) begin
      csum_w = csum_w - 52'(d_r);
    end
    cshift_w = (csum_w + 52'sd134217728) >>> 28;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      vrst_pkg::MB_IDLE:   if (ang_we) state_nxt = vrst_pkg::MB_LOAD;
      vrst_pkg::MB_LOAD:   state_nxt = vrst_pkg::MB_REDUCE;
      vrst_pkg::MB_REDUCE: if (in_range) state_nxt = vrst_pkg::MB_CORDIC;
      vrst_pkg::MB_CORDIC: begin
        if (iter_r == 4'(vrst_pkg::CordicSteps - 1)) state_nxt = vrst_pkg::MB_FINISH;
      end
      vrst_pkg::MB_FINISH: begin
        state_nxt = (ang_idx_r == 2'd2) ? vrst_pkg::MB_COEF : vrst_pkg::MB_LOAD;
      end
      vrst_pkg::MB_COEF: begin
        if (cidx_r == 4'd8 && ph_r == 2'd2) state_nxt = vrst_pkg::MB_IDLE;
      end
      default: state_nxt = vrst_pkg::MB_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vrst_pkg::MB_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ang_idx_r <= '0;
      cidx_r    <= '0;
      ph_r      <= '0;
      for (int i = 0; i < 9; i++) begin
        coef_r[i] <= (i % 4 == 0) ? K : 16'sd0;
      end
    end else begin
      unique case (state_r)
        vrst_pkg::MB_IDLE: begin
          ang_idx_r <= '0;
          cidx_r    <= '0;
          ph_r      <= '0;
        end
        vrst_pkg::MB_LOAD: r_r <= 17'(angle_r[ang_idx_r]);
        vrst_pkg::MB_REDUCE: begin
          if (r_r < 17'sd0) begin
            r_r <= r_r + 17'(vrst_pkg::FullTurn);
          end else if (!in_range) begin
            r_r <= r_r - 17'(vrst_pkg::FullTurn);
          end else begin
            q_r    <= q_w;
            zero_r <= (rem_w == 17'sd0);
            x_r    <= 32'(vrst_pkg::CordicX0);
            y_r    <= '0;
            z_r    <= 30'(rem_w) <<< 14;
            iter_r <= '0;
          end
        end
        vrst_pkg::MB_CORDIC: begin
          if (z_r >= 30'sd0) begin
            x_r <= x_r - ys_w;
            y_r <= y_r + xs_w;
            z_r <= z_r - vrst_pkg::atan_lut(iter_r);
          end else begin
            x_r <= x_r + ys_w;
            y_r <= y_r - xs_w;
            z_r <= z_r + vrst_pkg::atan_lut(iter_r);
          end
          iter_r <= iter_r + 4'd1;
        end
        vrst_pkg::MB_FINISH: begin
          sn_r[ang_idx_r] <= sn_w;
          cs_r[ang_idx_r] <= cs_w;
          ang_idx_r       <= ang_idx_r + 2'd1;
        end
        vrst_pkg::MB_COEF: begin
          unique case (ph_r)
            2'd0: begin
              m1_r <= op_a * op_b;
              m2_r <= op_d * op_e;
              ph_r <= 2'd1;
            end
            2'd1: begin
              t_r  <= 48'(m1_r) * 48'(op_c);
              d_r  <= 46'(m2_r) <<< 14;
              ph_r <= 2'd2;
            end
            default: begin
              coef_r[cidx_r] <= vrst_pkg::sat16(cshift_w);
              cidx_r         <= cidx_r + 4'd1;
              ph_r           <= 2'd0;
            end
          endcase
        end
        default: ;
      endcase
    end
  end

  // ---------------- vertex pipeline ----------------
  logic signed [15:0] pos_w [3];
  logic signed [15:0] nrm_w [3];
  logic               v1_r, v2_r, v3_r, v4_r;
  logic signed [31:0] pp_r [9];
  logic signed [31:0] pn_r [9];
  logic signed [33:0] accp_r [3];
  logic signed [33:0] accn_r [3];
  logic signed [50:0] sp_r [3];
  logic signed [15:0] nq_r [3];
  logic signed [15:0] po_r [3];
  logic signed [15:0] no_r [3];

  assign pos_w[0] = in_pos_x;
  assign pos_w[1] = in_pos_y;
  assign pos_w[2] = in_pos_z;
  assign nrm_w[0] = in_nrm_x;
  assign nrm_w[1] = in_nrm_y;
  assign nrm_w[2] = in_nrm_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        pp_r[r*3+k] <= coef_r[r*3+k] * pos_w[k];
        pn_r[r*3+k] <= coef_r[r*3+k] * nrm_w[k];
      end
      accp_r[r] <= 34'(pp_r[r*3]) + 34'(pp_r[r*3+1]) + 34'(pp_r[r*3+2]);
      accn_r[r] <= 34'(pn_r[r*3]) + 34'(pn_r[r*3+1]) + 34'(pn_r[r*3+2]);
      sp_r[r]   <= 51'(accp_r[r]) * 51'(signed'({1'b0, scale_r[16*r +: 16]}));
      nq_r[r]   <= vrst_pkg::sat16((52'(accn_r[r]) + 52'sd8192) >>> 14);
      po_r[r]   <= vrst_pkg::sat16((52'(sp_r[r]) +
                   (52'(signed'(offset_r[16*r +: 16])) <<< 22) +
                   52'sd536870912) >>> 30);
      no_r[r]   <= nq_r[r];
    end
  end

  assign out_valid     = v4_r;
  assign out_new_pos_x = po_r[0];
  assign out_new_pos_y = po_r[1];
  assign out_new_pos_z = po_r[2];
  assign out_new_nrm_x = no_r[0];
  assign out_new_nrm_y = no_r[1];
  assign out_new_nrm_z = no_r[2];

endmodule
